FILE: hdl/sdms_pkg.sv
// Shared constants for the stable descending merge sorter.
// No dependencies; imported by sdms_bank and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sdms_pkg;

   localparam int SDMS_MAX_ITEMS = 64;   // default set capacity
   localparam int SDMS_KEY_BITS  = 32;   // default key width
   localparam int SLOT_BITS      = 6;    // width of the arrival position

endpackage : sdms_pkg

`default_nettype wire

FILE: hdl/sdms_bank.sv
// Entry store of the sorter: one write port, two registered read ports.
// Depends on sdms_pkg for parameter defaults.
`timescale 1ns / 1ps
`default_nettype none

module sdms_bank
   import sdms_pkg::*;
#(
   parameter int DEPTH = SDMS_MAX_ITEMS,
   parameter int DW    = SDMS_KEY_BITS + SLOT_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [DW-1:0]              wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_l,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_r,
   output logic      [DW-1:0]              rd_data_l,
   output logic      [DW-1:0]              rd_data_r
);

   logic [DW-1:0] store_ff [DEPTH];
   logic [DW-1:0] rd_l_ff;
   logic [DW-1:0] rd_r_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_l_ff <= store_ff[rd_addr_l];
      rd_r_ff <= store_ff[rd_addr_r];
   end

   assign rd_data_l = rd_l_ff;
   assign rd_data_r = rd_r_ff;

endmodule : sdms_bank

`default_nettype wire

FILE: hdl/stable_descending_merge_sort_top.sv
// Stable descending merge sorter, top level. Uses sdms_pkg and two sdms_bank stores.
// Loading: one key per cycle while req_tready is high.
// Sorting after the tlast request: bottom-up merge, one output entry per cycle from the
//   two read ports of the source bank, with a setup state per run pair and per pass.
// Results: one per cycle under rsp_tready; each passes the store read and result registers.
// Reset (synchronous, active high) empties the set and the result register; store
//   contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module stable_descending_merge_sort_top
   import sdms_pkg::*;
#(
   parameter int MAX_ITEMS = SDMS_MAX_ITEMS,
   parameter int KEY_BITS  = SDMS_KEY_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((KEY_BITS + 7) / 8) * 8 - 1:0]  req_tdata,  // key_value
   input  wire logic                                   req_tlast,  // final_item
   // result channel
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // origin_slot [5:0], sorted_key above it, zero fill to whole bytes
   output logic [((SLOT_BITS + KEY_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                        rsp_tuser,  // overflowed
   output logic                                        rsp_tlast   // run_end
);

   localparam int AW   = $clog2(MAX_ITEMS);       // store address
   localparam int CW   = $clog2(MAX_ITEMS + 1);   // count 0..MAX_ITEMS
   localparam int EW   = CW + 1;                  // run bounds before clamping
   localparam int DW   = SLOT_BITS + KEY_BITS;    // store entry {slot, key}
   localparam int RTDW = ((SLOT_BITS + KEY_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      S_LOAD,    // taking keys
      S_PASS,    // start of a merge pass, or done
      S_RUN,     // set up the bounds of one pair of runs
      S_MERGE,   // one merged entry per cycle
      S_EMIT     // stream results out
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;      // keys in the current set
   logic              ovf_ff, ovf_in;          // a key was dropped
   logic              src_b_ff, src_b_in;      // source bank of the pass is B
   logic [EW-1:0]     width_ff, width_in;      // run length of the pass
   logic [CW-1:0]     lo_ff, lo_in;            // start of the run pair
   logic [CW-1:0]     l_ff, l_in;              // left head
   logic [CW-1:0]     r_ff, r_in;              // right head
   logic [CW-1:0]     mid_ff, mid_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     o_ff, o_in;              // merge write index
   logic [CW-1:0]     e_ff, e_in;              // emit index, entry in read data

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic [KEY_BITS-1:0]  rsp_key_ff, rsp_key_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic                 rsp_last_ff, rsp_last_in;

   // store ports
   logic [AW-1:0]  rd_addr_l, rd_addr_r;
   logic [DW-1:0]  a_rd_l, a_rd_r, b_rd_l, b_rd_r;
   logic [DW-1:0]  src_l, src_r;
   logic           a_wr_en, b_wr_en;
   logic [AW-1:0]  wr_addr;
   logic [DW-1:0]  wr_data;

   // merge decision
   logic           take_left;
   logic [CW-1:0]  l_next, r_next;
   logic [EW-1:0]  mid_sum, hi_sum;
   logic [CW-1:0]  mid_clip, hi_clip;
   logic           req_fire, rsp_load;
   logic [CW-1:0]  e_next;

   assign req_tready = (state_ff == S_LOAD);
   assign req_fire   = req_tvalid && req_tready;

   assign src_l = src_b_ff ? b_rd_l : a_rd_l;
   assign src_r = src_b_ff ? b_rd_r : a_rd_r;

   // Left wins ties, and an exhausted run never wins.
   assign take_left = (r_ff == hi_ff) ||
                      ((l_ff != mid_ff) && (src_l[KEY_BITS-1:0] >= src_r[KEY_BITS-1:0]));
   assign l_next    = take_left ? l_ff + CW'(1) : l_ff;
   assign r_next    = take_left ? r_ff : r_ff + CW'(1);

   // Run bounds clamped to the set size.
   assign mid_sum  = EW'(lo_ff) + width_ff;
   assign hi_sum   = EW'(lo_ff) + (width_ff << 1);
   assign mid_clip = (mid_sum > EW'(count_ff)) ? count_ff : mid_sum[CW-1:0];
   assign hi_clip  = (hi_sum > EW'(count_ff)) ? count_ff : hi_sum[CW-1:0];

   // Result register takes the next entry whenever it is empty or being drained.
   assign rsp_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign e_next   = e_ff + CW'(1);

   // Read addresses: the read data of the next cycle must hold the entries needed then.
   always_comb begin
      rd_addr_l = '0;
      rd_addr_r = '0;
      case (state_ff)
         S_RUN: begin
            rd_addr_l = lo_ff[AW-1:0];
            rd_addr_r = mid_clip[AW-1:0];
         end
         S_MERGE: begin
            rd_addr_l = l_next[AW-1:0];
            rd_addr_r = r_next[AW-1:0];
         end
         S_EMIT: begin
            rd_addr_l = rsp_load ? e_next[AW-1:0] : e_ff[AW-1:0];
         end
         default: begin
            rd_addr_l = '0;
            rd_addr_r = '0;
         end
      endcase
   end

   // Writes: loading fills bank A; a merge writes the bank that is not the source.
   always_comb begin
      a_wr_en = 1'b0;
      b_wr_en = 1'b0;
      wr_addr = o_ff[AW-1:0];
      wr_data = take_left ? src_l : src_r;
      if (state_ff == S_LOAD) begin
         a_wr_en = req_fire && (count_ff < CW'(MAX_ITEMS));
         wr_addr = count_ff[AW-1:0];
         wr_data = {SLOT_BITS'(count_ff), req_tdata[KEY_BITS-1:0]};
      end else if (state_ff == S_MERGE) begin
         a_wr_en = src_b_ff;
         b_wr_en = !src_b_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      src_b_in     = src_b_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      o_in         = o_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  width_in = EW'(1);
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            lo_in = '0;
            if (width_ff >= EW'(count_ff)) begin
               e_in     = '0;     // read of entry 0 issued this cycle
               state_in = S_EMIT;
            end else begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            l_in     = lo_ff;
            r_in     = mid_clip;
            mid_in   = mid_clip;
            hi_in    = hi_clip;
            o_in     = lo_ff;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            l_in = l_next;
            r_in = r_next;
            o_in = o_ff + CW'(1);
            if (o_ff + CW'(1) == hi_ff) begin
               lo_in = hi_ff;
               if (hi_ff == count_ff) begin
                  src_b_in = !src_b_ff;
                  width_in = width_ff << 1;
                  state_in = S_PASS;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = src_l[DW-1:KEY_BITS];
               rsp_key_in   = src_l[KEY_BITS-1:0];
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = (e_next == count_ff);
               e_in         = e_next;
               if (e_next == count_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  src_b_in = 1'b0;
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         src_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         src_b_ff     <= src_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff    <= width_in;
      lo_ff       <= lo_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      o_ff        <= o_in;
      e_ff        <= e_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   sdms_bank #(
      .DEPTH (MAX_ITEMS),
      .DW    (DW)
   ) u_bank_a (
      .clock     (clock),
      .wr_en     (a_wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_l (rd_addr_l),
      .rd_addr_r (rd_addr_r),
      .rd_data_l (a_rd_l),
      .rd_data_r (a_rd_r)
   );

   sdms_bank #(
      .DEPTH (MAX_ITEMS),
      .DW    (DW)
   ) u_bank_b (
      .clock     (clock),
      .wr_en     (b_wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_l (rd_addr_l),
      .rd_addr_r (rd_addr_r),
      .rd_data_l (b_rd_l),
      .rd_data_r (b_rd_r)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RTDW'({rsp_key_ff, rsp_slot_ff});
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   // The set never grows past capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("set count beyond capacity");

   // Merge heads and write index stay inside the current run pair.
   a_merge_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (o_ff < hi_ff) && (l_ff <= mid_ff) && (r_ff <= hi_ff)
                                && (mid_ff <= hi_ff))
      else $error("merge index out of run bounds");

   // Emission only reads stored entries of the set.
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (e_ff < count_ff))
      else $error("emit index beyond set");

   // The last result of a set returns the block to loading.
   a_last_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (e_next == count_ff)) |=> (state_ff == S_LOAD) && rsp_last_ff)
      else $error("end of set not followed by load");

endmodule : stable_descending_merge_sort_top

`default_nettype wire

FILE: verif/sdms_sort_scoreboard.sv
// Scoreboard for the stable descending merge sorter: predicts the sorted set
// from the accepted requests and checks each result. Depends on sdms_pkg.
`timescale 1ns / 1ps

package sdms_sort_scoreboard_pkg;
   import sdms_pkg::*;

   typedef struct {
      logic [SLOT_BITS-1:0]     slot;
      logic [SDMS_KEY_BITS-1:0] key;
      logic                     overflowed;
      logic                     run_end;
   } sorted_entry_type;

   class sort_scoreboard;
      logic [SDMS_KEY_BITS-1:0] set_keys[$];
      bit                       set_overflow;
      sorted_entry_type         sorted_q[$];
      int                       failures;

      function new();
         set_overflow = 1'b0;
         failures     = 0;
      endfunction

      // Keys past capacity are dropped; tlast closes the set and queues its sorted order.
      function void note_request(input logic [SDMS_KEY_BITS-1:0] key, input logic last);
         int               rank [SDMS_MAX_ITEMS];
         int               pos;
         int               n;
         sorted_entry_type entry;
         if (set_keys.size() < SDMS_MAX_ITEMS) begin
            set_keys.push_back(key);
         end else begin
            set_overflow = 1'b1;
         end
         if (!last) return;
         n = set_keys.size();
         // stable insertion: a key only moves ahead of strictly smaller ones
         for (int i = 0; i < n; i++) begin
            pos = i;
            while (pos > 0 && set_keys[rank[pos-1]] < set_keys[i]) begin
               rank[pos] = rank[pos-1];
               pos--;
            end
            rank[pos] = i;
         end
         for (int i = 0; i < n; i++) begin
            entry.slot       = SLOT_BITS'(rank[i]);
            entry.key        = set_keys[rank[i]];
            entry.overflowed = set_overflow;
            entry.run_end    = (i == n - 1);
            sorted_q.push_back(entry);
         end
         set_keys.delete();
         set_overflow = 1'b0;
      endfunction

      function void check_result(input logic [SLOT_BITS-1:0] slot,
                                 input logic [SDMS_KEY_BITS-1:0] key,
                                 input logic overflowed, input logic run_end);
         sorted_entry_type want;
         if (sorted_q.size() == 0) begin
            $display("%0t: unexpected result slot %0d key %h", $time, slot, key);
            failures++;
            return;
         end
         want = sorted_q.pop_front();
         if (slot !== want.slot) begin
            $display("%0t: origin_slot expected %0d, got %0d", $time, want.slot, slot);
            failures++;
         end
         if (key !== want.key) begin
            $display("%0t: sorted_key expected %h, got %h", $time, want.key, key);
            failures++;
         end
         if (overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %b, got %b", $time, want.overflowed,
                     overflowed);
            failures++;
         end
         if (run_end !== want.run_end) begin
            $display("%0t: run_end expected %b, got %b", $time, want.run_end, run_end);
            failures++;
         end
      endfunction

      function int pending();
         return sorted_q.size();
      endfunction
   endclass

endpackage : sdms_sort_scoreboard_pkg

FILE: verif/stable_descending_merge_sort_top_test.sv
// Testbench top for stable_descending_merge_sort_top: drives key sets, stalls the
// result side and checks every result. Depends on sdms_pkg and sdms_sort_scoreboard_pkg.
`timescale 1ns / 1ps

module stable_descending_merge_sort_top_test;
   import sdms_pkg::*;
   import sdms_sort_scoreboard_pkg::*;

   localparam int REQ_W       = ((SDMS_KEY_BITS + 7) / 8) * 8;
   localparam int RSP_W       = ((SLOT_BITS + SDMS_KEY_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 200000;   // far beyond the slowest legal run
   localparam int LONG_HOLD   = 400;      // receiver hold-off, lets the sorter back up
   localparam int ITEM_TARGET = 310;

   // how the keys of a random set are drawn
   typedef enum int {KEYS_WIDE, KEYS_TIED, KEYS_EDGE} key_mix_type;

   // traffic phases: sender/receiver idle mix, then free running, then drain
   typedef enum int {PH_SLOW_RX, PH_SLOW_TX, PH_FREE, PH_DRAIN} traffic_phase_type;

   logic                        clock;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_W-1:0]            req_tdata  = '0;    // key_value
   logic                        req_tlast  = 1'b0;  // final_item
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_W-1:0]            rsp_tdata;          // origin_slot, sorted_key, zero fill
   logic                        rsp_tuser;          // overflowed
   logic                        rsp_tlast;          // run_end

   sort_scoreboard     sb = new();
   traffic_phase_type  traffic_phase = PH_SLOW_RX;
   int                 items_sent    = 0;

   stable_descending_merge_sort_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hang or missing results end the run here
   initial begin
      int cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // percent of cycles the sender holds back before a request
   function automatic int tx_idle_pct();
      case (traffic_phase)
         PH_SLOW_RX: return 24;
         PH_SLOW_TX: return 75;
         default:    return 0;
      endcase
   endfunction

   function automatic int rx_idle_pct();
      case (traffic_phase)
         PH_SLOW_RX: return 75;
         PH_SLOW_TX: return 24;
         default:    return 0;
      endcase
   endfunction

   function automatic logic [SDMS_KEY_BITS-1:0] pick_key(input key_mix_type mix);
      case (mix)
         KEYS_TIED: return SDMS_KEY_BITS'($urandom_range(3));   // many equal keys
         KEYS_EDGE: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return '1;
               2:       return {1'b1, {(SDMS_KEY_BITS-1){1'b0}}};
               default: return {1'b0, {(SDMS_KEY_BITS-1){1'b1}}};
            endcase
         end
         default:   return SDMS_KEY_BITS'($urandom);
      endcase
   endfunction

   // One request: random idle cycles first, then hold valid until accepted.
   // valid only drops when an idle cycle is actually inserted, so back-to-back
   // requests never see a low/high pair in one step.
   task automatic send_request(input logic [SDMS_KEY_BITS-1:0] key, input logic last);
      while ($urandom_range(99) < tx_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(key);
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(key, last);
      items_sent++;
   endtask

   task automatic send_set(input int n, input key_mix_type mix);
      for (int i = 0; i < n; i++) send_request(pick_key(mix), i == n - 1);
   endtask

   // random small sets until the item count reaches the given mark
   task automatic send_small_sets(input int upto);
      while (items_sent < upto)
         send_set($urandom_range(1, 12), key_mix_type'($urandom_range(2)));
   endtask

   // result side: check on each handshake, then pick next tready.
   // The first time free running is seen, tready stays low for a long stretch
   // so the sorter fills up and must stall its request side.
   initial begin
      int hold_left       = 0;
      bit long_hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[SLOT_BITS-1:0],
                            rsp_tdata[SLOT_BITS +: SDMS_KEY_BITS], rsp_tuser, rsp_tlast);
         if (traffic_phase == PH_FREE && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct());
         end
      end
   end

   // stimulus: directed sets, random sets across the idle phases, then drain
   initial begin
      // directed sets, back to back: lone max key, ascending pair, all equal
      // (stability), interleaved ties, ascending extremes, descending extremes
      logic [SDMS_KEY_BITS-1:0] directed_keys [22] = '{
         32'hFFFF_FFFF,
         32'h0000_0000, 32'hFFFF_FFFF,
         32'h7, 32'h7, 32'h7, 32'h7,
         32'h3, 32'h9, 32'h3, 32'h9, 32'h5,
         32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
         32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h0
      };
      int directed_len [6] = '{1, 2, 4, 5, 6, 4};
      int idx = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      traffic_phase = PH_SLOW_RX;
      for (int s = 0; s < 6; s++)
         for (int i = 0; i < directed_len[s]; i++) begin
            send_request(directed_keys[idx], i == directed_len[s] - 1);
            idx++;
         end
      send_small_sets(70);

      // the other way round; full capacity and two overflowed sets whose
      // tlast request itself is dropped
      traffic_phase = PH_SLOW_TX;
      send_set(SDMS_MAX_ITEMS, KEYS_WIDE);
      send_set(SDMS_MAX_ITEMS + 1, KEYS_TIED);
      send_set(2, KEYS_EDGE);
      send_set(SDMS_MAX_ITEMS + 3, KEYS_EDGE);
      send_small_sets(230);

      // no idling; receiver's long hold-off starts here
      traffic_phase = PH_FREE;
      send_small_sets(ITEM_TARGET);
      req_tvalid <= 1'b0;

      traffic_phase = PH_DRAIN;
      while (sb.pending() != 0) @(posedge clock);
      // any stray results would show here
      repeat (100) @(posedge clock);
      if (sb.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
